// ===== rtl/core/bsp_pkg.sv =====
// Shared types and constants for the bit sieve prime test block.
package bsp_pkg;

  // Default map size in bytes and the fixed byte width of the map
  localparam int MaxMapBytesDef = 8192;
  localparam int BitsPerByte    = 8;

  // Widths fixed by the beat fields and the size register
  localparam int NumberW = 16;
  localparam int SizeW   = 14;

  // Reset value of the size register
  localparam logic [SizeW-1:0] SieveBytesRst = 14'd100;

  // Depth of the queue between front and back
  localparam int QueueDepth = 2;

  // Map byte 0 after a clear: 0 and 1 are marked as not prime
  localparam logic [BitsPerByte-1:0] FirstByteInit = 8'h03;

  // Operation codes of an input beat
  typedef enum logic {
    OpBuild = 1'b0,
    OpQuery = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StRange    = 2'd1,
    StNotBuilt = 2'd2
  } status_e;

  // Job class decided by the front
  typedef enum logic [1:0] {
    KindBuild    = 2'd0,
    KindRead     = 2'd1,
    KindRange    = 2'd2,
    KindNotBuilt = 2'd3
  } kind_e;

  // Input beat
  typedef struct packed {
    op_e                op;
    logic [NumberW-1:0] number;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic    prime_flag;
    status_e status;
  } result_t;

  // Queue entry
  typedef struct packed {
    kind_e              kind;
    logic [NumberW-1:0] number;
  } job_t;

  // Front to queue push
  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

endpackage

// ===== rtl/core/bsp_front.sv =====
// Front end: accepts beats, classifies them and pushes jobs into the queue.
module bsp_front #(
  parameter int MaxMapBytes = bsp_pkg::MaxMapBytesDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  bsp_pkg::cmd_t                          cmd_i,
  input  logic [$clog2(MaxMapBytes)+3:0]         limit_i,
  input  logic                                   q_full_i,
  output bsp_pkg::push_t                         push_o
);
  import bsp_pkg::*;

  localparam int AddrW = $clog2(MaxMapBytes);
  localparam int LimW  = AddrW + 4;
  localparam int CmpW  = (LimW > NumberW) ? LimW : NumberW;

  logic built_q, built_d;
  logic accept;
  logic over_limit;

  // Stall the command side only when the queue has no room
  assign busy   = q_full_i;
  assign accept = start & ~q_full_i;

  assign over_limit = CmpW'(cmd_i.number) >= CmpW'(limit_i);

  // Classify the beat; builds always finish, so a build in flight counts as built
  always_comb begin
    push_o.push       = accept;
    push_o.job.number = cmd_i.number;
    if (cmd_i.op == OpBuild) begin
      push_o.job.kind = KindBuild;
    end else if (!built_q) begin
      push_o.job.kind = KindNotBuilt;
    end else if (over_limit) begin
      push_o.job.kind = KindRange;
    end else begin
      push_o.job.kind = KindRead;
    end
  end

  assign built_d = built_q | (accept & (cmd_i.op == OpBuild));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      built_q <= 1'b0;
    end else begin
      built_q <= built_d;
    end
  end

endmodule

// ===== rtl/core/bsp_fifo.sv =====
// Short job queue between the front and the back.
module bsp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bsp_pkg::push_t push_i,
  input  logic           pop_i,
  output bsp_pkg::job_t  head_o,
  output logic           empty_o,
  output logic           full_o
);
  import bsp_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign head_o  = slot_q[rd_ptr_q];

  assign do_push = push_i.push & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Pointer and fill count update with wraparound
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

// ===== rtl/core/bsp_back.sv =====
// Back end: composite map memory, sieve build sequencer and query reads.
module bsp_back #(
  parameter int MaxMapBytes = bsp_pkg::MaxMapBytesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [$clog2(MaxMapBytes)+3:0] limit_i,
  input  bsp_pkg::job_t                  head_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  output logic                           result_valid_o,
  output bsp_pkg::result_t               result_o
);
  import bsp_pkg::*;

  localparam int AddrW = $clog2(MaxMapBytes);
  localparam int PosW  = AddrW + 3;
  localparam int LimW  = AddrW + 4;

  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SClear  = 6'b000010,
    SCheck  = 6'b000100,
    SWait   = 6'b001000,
    SMark   = 6'b010000,
    SFinish = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [BitsPerByte-1:0] map_mem [MaxMapBytes];
  logic [BitsPerByte-1:0] rdata_q;

  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic [PosW-1:0]  cand_q, cand_d;
  logic [LimW-1:0]  sq_q, sq_d;
  logic [LimW-1:0]  mult_q, mult_d;

  logic             s1_valid_q, s1_valid_d;
  kind_e            s1_kind_q, s1_kind_d;
  logic [2:0]       s1_bit_q, s1_bit_d;

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             clr_en;
  logic             mark_en;
  logic [PosW-1:0]  query_pos;
  logic [PosW-1:0]  mark_pos;
  logic [LimW-1:0]  sq_next;

  assign query_pos = PosW'(head_i.number);
  assign mark_pos  = mult_q[PosW-1:0];
  // (i+1)^2 = i^2 + 2i + 1
  assign sq_next   = sq_q + LimW'({cand_q, 1'b1});

  // Sequencer: query dispatch, clear sweep, then the sieve walk
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    cand_d     = cand_q;
    sq_d       = sq_q;
    mult_d     = mult_q;
    s1_valid_d = 1'b0;
    s1_kind_d  = s1_kind_q;
    s1_bit_d   = s1_bit_q;
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = query_pos[PosW-1:3];
    clr_en     = 1'b0;
    mark_en    = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.kind == KindBuild) begin
            clr_addr_d = '0;
            state_d    = SClear;
          end else begin
            s1_valid_d = 1'b1;
            s1_kind_d  = head_i.kind;
            s1_bit_d   = query_pos[2:0];
            rd_en      = (head_i.kind == KindRead);
          end
        end
      end
      SClear: begin
        clr_en     = 1'b1;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AddrW'(MaxMapBytes - 1)) begin
          cand_d  = PosW'(2);
          sq_d    = LimW'(4);
          state_d = SCheck;
        end
      end
      SCheck: begin
        if (sq_q >= limit_i) begin
          state_d = SFinish;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cand_q[PosW-1:3];
          state_d = SWait;
        end
      end
      SWait: begin
        if (rdata_q[cand_q[2:0]]) begin
          cand_d  = cand_q + 1'b1;
          sq_d    = sq_next;
          state_d = SCheck;
        end else begin
          mult_d  = LimW'({cand_q, 1'b0});
          state_d = SMark;
        end
      end
      SMark: begin
        if (mult_q >= limit_i) begin
          cand_d  = cand_q + 1'b1;
          sq_d    = sq_next;
          state_d = SCheck;
        end else begin
          mark_en = 1'b1;
          mult_d  = mult_q + LimW'(cand_q);
        end
      end
      SFinish: begin
        s1_valid_d = 1'b1;
        s1_kind_d  = KindBuild;
        state_d    = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    clr_addr_q <= clr_addr_d;
    cand_q     <= cand_d;
    sq_q       <= sq_d;
    mult_q     <= mult_d;
    s1_kind_q  <= s1_kind_d;
    s1_bit_q   <= s1_bit_d;
  end

  // Map memory: byte clear writes, single bit marks, registered read
  always_ff @(posedge clk_i) begin
    if (clr_en) begin
      map_mem[clr_addr_q] <= (clr_addr_q == '0) ? FirstByteInit : '0;
    end else if (mark_en) begin
      map_mem[mark_pos[PosW-1:3]][mark_pos[2:0]] <= 1'b1;
    end
    if (rd_en) begin
      rdata_q <= map_mem[rd_addr];
    end
  end

  // Result beat from the stage register and the read data
  always_comb begin
    result_valid_o      = s1_valid_q;
    result_o.prime_flag = (s1_kind_q == KindRead) & ~rdata_q[s1_bit_q];
    case (s1_kind_q)
      KindRange:    result_o.status = StRange;
      KindNotBuilt: result_o.status = StNotBuilt;
      default:      result_o.status = StOk;
    endcase
  end

endmodule

// ===== rtl/core/bit_sieve_prime_test.sv =====
// Top level of the bit sieve prime test: size register, front, queue, back.
//
// Command channel: a beat (op, number) is taken at a rising edge where start is
// high and busy is low. op selects a sieve rebuild or a primality query.
// Result channel: result_valid_o marks each result beat for exactly one cycle;
// every command gives exactly one result, in command order.
// Configuration: cfg_we_i writes cfg_wdata_i into the map size (in bytes);
// write it only while no command is outstanding.
// Query path: a taken command is written into the job queue, then popped
// and read through the single registered read port of the map memory into
// the result stage; queries sustain one per cycle while no rebuild runs.
// busy rises only when the two-entry job queue fills. A rebuild dispatches,
// sweeps the map clear (one byte per cycle), reads the map bit of each
// candidate i with i*i below the limit, marks the multiples of each unmarked
// one, then a final check and a finish step give its result; the queue stalls meanwhile.
// Reset: the map is not cleared; it reads as not built until the first
// rebuild, and the size register returns to 100 bytes.
// The result side has no back-pressure: results are presented and taken at once.
module bit_sieve_prime_test #(
  parameter int MaxMapBytes = bsp_pkg::MaxMapBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  bsp_pkg::cmd_t                cmd_i,
  output logic                         result_valid_o,
  output bsp_pkg::result_t             result_o,
  input  logic                         cfg_we_i,
  input  logic [bsp_pkg::SizeW-1:0]    cfg_wdata_i
);
  import bsp_pkg::*;

  localparam int AddrW  = $clog2(MaxMapBytes);
  localparam int LimW   = AddrW + 4;
  localparam int SatW   = (AddrW + 1 > SizeW) ? AddrW + 1 : SizeW;

  logic [SizeW-1:0] sieve_bytes_q;
  logic [SatW-1:0]  bytes_ext;
  logic [SatW-1:0]  bytes_sat;
  logic [LimW-1:0]  limit;

  push_t push;
  job_t  head;
  logic  q_empty, q_full, pop;

  // Size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sieve_bytes_q <= SieveBytesRst;
    end else if (cfg_we_i) begin
      sieve_bytes_q <= cfg_wdata_i;
    end
  end

  // Limit in bits, with the byte count saturated to the map size
  assign bytes_ext = SatW'(sieve_bytes_q);
  assign bytes_sat = (bytes_ext > SatW'(MaxMapBytes)) ? SatW'(MaxMapBytes) : bytes_ext;
  assign limit     = LimW'({bytes_sat, 3'b000});

  bsp_front #(
    .MaxMapBytes(MaxMapBytes)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .limit_i (limit),
    .q_full_i(q_full),
    .push_o  (push)
  );

  bsp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  bsp_back #(
    .MaxMapBytes(MaxMapBytes)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limit_i       (limit),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // A prime answer only comes with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.prime_flag |-> result_o.status == StOk)
    else $error("prime flag with non-ok status");

  // An accepted beat leaves the queue non-empty or is popped at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !pop |=> !q_empty)
    else $error("accepted beat lost");

  // The back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop on empty queue");

  // Each pop of a query gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && head.kind != KindBuild |=> result_valid_o)
    else $error("query result missing");

endmodule
